/* rtl/horizontal_halfpel_filter_unit_defines.svh */
// Assertion macros of the horizontal half-pel filter, used by the result register hhf_out.
`ifndef HORIZONTAL_HALFPEL_FILTER_UNIT_DEFINES_SVH
`define HORIZONTAL_HALFPEL_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define HHF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HHF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HHF_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define HHF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/hhf_pkg.sv */
// Shared types and constants of the horizontal half-pel filter.
package hhf_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MIN_WIDTH  = 6;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned RW_W       = COL_W + 1;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned TAPS       = 6;
  localparam int unsigned BURST      = 4;
  localparam int unsigned CNT_W      = $clog2(BURST + 1);
  localparam int unsigned IDX_W      = $clog2(BURST);

  typedef enum logic [0:0] {
    REG_FILTER_MODE = 1'b0,
    REG_ROW_WIDTH   = 1'b1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [TAPS-1:0][PIX_W-1:0] taps;
    logic                       has_main;
    logic                       six;
    logic                       last;
  } stage_t;

  typedef struct packed {
    logic [BURST-1:0][PIX_W-1:0] vals;
    logic [CNT_W-1:0]            cnt;
  } bundle_t;

endpackage

/* rtl/hhf_front.sv */
// Configuration registers, pixel window, column counter and input stage register.
module hhf_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  hhf_pkg::cfg_reg_e        cfg_addr_i,
  input  logic [hhf_pkg::RW_W-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  hhf_pkg::pix_t            in_pixel_i,
  input  logic                     adv_ok_i,
  output logic                     stage_load_o,
  output hhf_pkg::stage_t          stage_o
);
  import hhf_pkg::*;

  logic                 mode_q;
  logic [RW_W-1:0]      width_q;
  logic [4:0][PIX_W-1:0] win_q;
  logic [COL_W-1:0]     col_q;
  logic                 st_valid_q;
  stage_t               st_q;
  stage_t               st_d;
  logic [RW_W-1:0]      w_c;
  logic [RW_W-1:0]      col_x;
  logic                 accept;

  always_comb begin
    if (width_q < RW_W'(MIN_WIDTH)) begin
      w_c = RW_W'(MIN_WIDTH);
    end else if (width_q > RW_W'(MAX_WIDTH)) begin
      w_c = RW_W'(MAX_WIDTH);
    end else begin
      w_c = width_q;
    end
  end

  assign col_x        = {1'b0, col_q};
  assign stage_load_o = st_valid_q && adv_ok_i;
  assign in_ready_o   = !st_valid_q || adv_ok_i;
  assign accept       = in_valid_i && in_ready_o;
  assign stage_o      = st_q;

  always_comb begin
    st_d.taps     = {in_pixel_i, win_q};
    st_d.last     = col_x >= (w_c - RW_W'(1));
    st_d.has_main = col_q >= COL_W'(3);
    st_d.six      = mode_q && (col_q >= COL_W'(5)) && ((col_x + RW_W'(2)) <= w_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b1;
      width_q    <= RW_W'(64);
      win_q      <= '0;
      col_q      <= '0;
      st_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_FILTER_MODE: mode_q  <= cfg_data_i[0];
          REG_ROW_WIDTH:   width_q <= cfg_data_i;
        endcase
      end
      if (accept) begin
        win_q      <= {in_pixel_i, win_q[4:1]};
        col_q      <= st_d.last ? '0 : col_q + COL_W'(1);
        st_valid_q <= 1'b1;
      end else if (stage_load_o) begin
        st_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q <= st_d;
    end
  end

endmodule

/* rtl/hhf_filter.sv */
// Six-tap and bilinear filter datapath that turns one stage entry into a result bundle.
module hhf_filter (
  input  hhf_pkg::stage_t  stage_i,
  output hhf_pkg::bundle_t bundle_o
);
  import hhf_pkg::*;

  function automatic pix_t avg2(input pix_t a, input pix_t b);
    logic [PIX_W:0] s;
    s = (PIX_W+1)'(a) + (PIX_W+1)'(b) + (PIX_W+1)'(1);
    return s[PIX_W:1];
  endfunction

  function automatic pix_t six_tap(input logic [TAPS-1:0][PIX_W-1:0] p);
    logic [14:0]        u;
    logic signed [14:0] v;
    logic signed [9:0]  q;
    pix_t               r;
    u = 15'(p[0]) + 15'(p[5]) + 15'(20) * (15'(p[2]) + 15'(p[3]))
      - 15'(5) * (15'(p[1]) + 15'(p[4])) + 15'(16);
    v = $signed(u);
    q = 10'(v >>> 5);
    if (q[9]) begin
      r = '0;
    end else if (q[8]) begin
      r = '1;
    end else begin
      r = q[7:0];
    end
    return r;
  endfunction

  pix_t main_pix;

  assign main_pix = stage_i.six ? six_tap(stage_i.taps) : avg2(stage_i.taps[2], stage_i.taps[3]);

  always_comb begin
    bundle_o.vals[0] = main_pix;
    bundle_o.vals[1] = avg2(stage_i.taps[3], stage_i.taps[4]);
    bundle_o.vals[2] = avg2(stage_i.taps[4], stage_i.taps[5]);
    bundle_o.vals[3] = stage_i.taps[5];
    priority if (stage_i.last) begin
      bundle_o.cnt = CNT_W'(BURST);
    end else if (stage_i.has_main) begin
      bundle_o.cnt = CNT_W'(1);
    end else begin
      bundle_o.cnt = '0;
    end
  end

endmodule

/* rtl/hhf_out.sv */
// Result register that holds one bundle and hands its pixels out one per transaction.
module hhf_out (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  hhf_pkg::bundle_t          bundle_i,
  output logic                      can_load_o,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,
  output logic                      m_axis_tlast,
  output logic                      m_axis_tuser
);
  import hhf_pkg::*;
  `include "horizontal_halfpel_filter_unit_defines.svh"

  logic [BURST-1:0][PIX_W-1:0] vals_q;
  logic [CNT_W-1:0]            rem_q;
  logic [IDX_W-1:0]            idx_q;
  logic                        take;

  assign m_axis_tvalid = rem_q != '0;
  assign take          = m_axis_tvalid && m_axis_tready;
  assign can_load_o    = (rem_q == '0) || ((rem_q == CNT_W'(1)) && m_axis_tready);
  assign m_axis_tdata  = vals_q[idx_q];
  assign m_axis_tlast  = idx_q == IDX_W'(BURST - 1);
  assign m_axis_tuser  = rem_q == CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      rem_q <= bundle_i.cnt;
      idx_q <= '0;
    end else if (take) begin
      rem_q <= rem_q - CNT_W'(1);
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      vals_q <= bundle_i.vals;
    end
  end

  `HHF_ASSERT_SAME(a_eor_ends_run, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
  `HHF_ASSERT_SAME(a_count_fits, clk_i, rst_ni, m_axis_tvalid, ({1'b0, idx_q} + rem_q) <= (CNT_W+1)'(BURST))
  `HHF_ASSERT_NEXT(a_load_starts_at_zero, clk_i, rst_ni, load_i, idx_q == '0)

endmodule

/* rtl/horizontal_halfpel_filter_unit.sv */
// Horizontal half-pel interpolation filter, top level.
// Accepts one 8-bit pixel per clock unless the output stalls, and emits the half-pel row
// through a one-bundle result register. A pixel is registered in the input stage, filtered
// combinationally from that stage and loaded into the result register, which hands out its results.
// Inside a row each pixel causes at most one result and the block sustains one pixel per
// clock while m_axis_tready is high; the last pixel of a row causes four results, drained
// one per transfer, so the input pauses while they drain. Results lag the input by three pixels.
module horizontal_halfpel_filter_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  hhf_pkg::cfg_reg_e        cfg_addr_i,
  input  logic [hhf_pkg::RW_W-1:0] cfg_data_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] pixel
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,   // [7:0] out_pixel
  output logic                     m_axis_tlast,   // end_of_row
  output logic                     m_axis_tuser    // [0] run_last
);
  import hhf_pkg::*;

  stage_t  stage;
  bundle_t bundle;
  logic    can_load;
  logic    stage_load;

  hhf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_pixel_i   (s_axis_tdata),
    .adv_ok_i     (can_load),
    .stage_load_o (stage_load),
    .stage_o      (stage)
  );

  hhf_filter u_filter (
    .stage_i  (stage),
    .bundle_o (bundle)
  );

  hhf_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (stage_load),
    .bundle_i      (bundle),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
